// ----- rtl/core/softmax_cross_entropy_loss_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the softmax cross-entropy loss block
// Implication checks on the rising edge of clk_i, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SOFTMAX_CROSS_ENTROPY_LOSS_ASSERT_SVH
`define SOFTMAX_CROSS_ENTROPY_LOSS_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SCE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sce assertion failed");
// next-cycle implication
`define SCE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sce assertion failed");
`else
`define SCE_ASSERT_IMP(lbl, ante, cons)
`define SCE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/sce_pkg.sv -----
// ----------------------------------------------------------------------------
// sce_pkg
// Widths, constants and register codes of the softmax cross-entropy loss block.
// ----------------------------------------------------------------------------
package sce_pkg;

  localparam int MAX_CLASSES   = 1024;
  localparam int CI_W          = $clog2(MAX_CLASSES) + 1;

  localparam int PROB_W        = 17;
  localparam int LABEL_W       = 11;
  localparam int LOSS_W        = 32;
  localparam int CNT_W         = 21;
  localparam int SUM_W         = 40;
  localparam int TERM_W        = 20;
  localparam int NORM_W        = 22;
  localparam int DVD_W         = SUM_W + 1;

  localparam int LOG_FRAC_BITS = 20;
  localparam int SH_W          = 5;
  localparam int LG_W          = SH_W + LOG_FRAC_BITS;
  localparam int PROD_W        = LG_W + 32;

  localparam logic [PROB_W-1:0] ONE_Q16   = PROB_W'(65536);
  localparam logic [31:0]       LN2_Q32   = 32'd2977044472;
  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_NORM_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_LABEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPATIAL_COUNT = 3'd4;

  // normalizer modes
  localparam logic [1:0] NORM_FULL  = 2'd0;
  localparam logic [1:0] NORM_VALID = 2'd1;
  localparam logic [1:0] NORM_BATCH = 2'd2;
  localparam logic [1:0] NORM_NONE  = 2'd3;

endpackage

// ----- rtl/core/sce_log.sv -----
// ----------------------------------------------------------------------------
// sce_log
// Iterative -ln(q/65536) in Q4.16: one squaring a cycle for the log2 fraction,
// then a scale by ln2 and a rounding step.
// ----------------------------------------------------------------------------
module sce_log (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sce_pkg::PROB_W-1:0]  q_i,
  output logic                        done_o,
  output logic [sce_pkg::TERM_W-1:0]  nlog_o
);
  import sce_pkg::*;

  typedef enum logic [2:0] {L_IDLE, L_SQR, L_LG, L_MUL, L_RND} state_e;

  localparam int CNT_LW = $clog2(LOG_FRAC_BITS);
  localparam logic [PROD_W:0] RND_HALF = (PROD_W+1)'(1) << 35;

  state_e                    state_q, state_d;
  logic [PROB_W-1:0]         m_q, m_d;
  logic [SH_W-1:0]           sh_q, sh_d;
  logic [LOG_FRAC_BITS-1:0]  frac_q, frac_d;
  logic [CNT_LW-1:0]         cnt_q, cnt_d;
  logic [LG_W-1:0]           lg_q, lg_d;
  logic [PROD_W-1:0]         prod_q, prod_d;
  logic                      done_q, done_d;
  logic [TERM_W-1:0]         res_q, res_d;

  logic [2*PROB_W-1:0]       sq;
  logic [PROB_W:0]           sq_hi;
  logic [PROD_W:0]           rsum;
  logic [SH_W-1:0]           lz;

  // count leading zeros of the 17-bit probability
  function automatic logic [SH_W-1:0] lzc(input logic [PROB_W-1:0] v);
    logic [SH_W-1:0] n;
    logic            found;
    n     = '0;
    found = 1'b0;
    for (int i = PROB_W - 1; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else      n = n + SH_W'(1);
      end
    end
    return n;
  endfunction

  assign lz    = lzc(q_i);
  assign sq    = (2*PROB_W)'(m_q) * (2*PROB_W)'(m_q);
  assign sq_hi = sq[2*PROB_W-1:16];
  assign rsum  = (PROD_W+1)'(prod_q) + RND_HALF;

  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    sh_d    = sh_q;
    frac_d  = frac_q;
    cnt_d   = cnt_q;
    lg_d    = lg_q;
    prod_d  = prod_q;
    done_d  = 1'b0;
    res_d   = res_q;
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          m_d     = q_i << lz;
          sh_d    = lz;
          frac_d  = '0;
          cnt_d   = '0;
          state_d = L_SQR;
        end
      end
      L_SQR: begin
        // a square at or above 2.0 yields a one bit and is halved
        if (sq_hi[PROB_W]) begin
          m_d    = sq_hi[PROB_W:1];
          frac_d = {frac_q[LOG_FRAC_BITS-2:0], 1'b1};
        end else begin
          m_d    = sq_hi[PROB_W-1:0];
          frac_d = {frac_q[LOG_FRAC_BITS-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_LW'(1);
        if (cnt_q == CNT_LW'(LOG_FRAC_BITS - 1)) state_d = L_LG;
      end
      L_LG: begin
        lg_d    = {sh_q, {LOG_FRAC_BITS{1'b0}}} - LG_W'(frac_q);
        state_d = L_MUL;
      end
      L_MUL: begin
        prod_d  = PROD_W'(lg_q) * PROD_W'(LN2_Q32);
        state_d = L_RND;
      end
      L_RND: begin
        res_d   = rsum[36+TERM_W-1:36];
        done_d  = 1'b1;
        state_d = L_IDLE;
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    sh_q   <= sh_d;
    frac_q <= frac_d;
    lg_q   <= lg_d;
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign nlog_o = res_q;

endmodule

// ----- rtl/core/sce_div.sv -----
// ----------------------------------------------------------------------------
// sce_div
// Restoring divider, one quotient bit a cycle; quotient saturates to 32 bits.
// ----------------------------------------------------------------------------
module sce_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sce_pkg::DVD_W-1:0]   dividend_i,
  input  logic [sce_pkg::NORM_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [sce_pkg::LOSS_W-1:0]  quo_o
);
  import sce_pkg::*;

  localparam int STEP_W = $clog2(DVD_W);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic [DVD_W-1:0]    dvd_q, dvd_d;
  logic [NORM_W-1:0]   rem_q, rem_d;
  logic [NORM_W-1:0]   dsr_q, dsr_d;
  logic [LOSS_W-1:0]   quo_q, quo_d;

  logic [NORM_W:0]     rem_sh;
  logic [NORM_W:0]     diff;
  logic                ge;

  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};
  assign diff   = rem_sh - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        cnt_d  = '0;
        dvd_d  = dividend_i;
        rem_d  = '0;
        dsr_d  = divisor_i;
      end
    end else begin
      // quotient bits shift in where dividend bits leave
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      rem_d = ge ? diff[NORM_W-1:0] : rem_sh[NORM_W-1:0];
      cnt_d = cnt_q + STEP_W'(1);
      if (cnt_q == STEP_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        quo_d  = (dvd_d[DVD_W-1:LOSS_W] != '0) ? {LOSS_W{1'b1}} : dvd_d[LOSS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- rtl/core/softmax_cross_entropy_loss.sv -----
// ----------------------------------------------------------------------------
// softmax_cross_entropy_loss
// Forward cross-entropy loss over streamed softmax probabilities.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): one probability per item, in class
// order, with the position's label; last_class_i closes a position and
// last_of_batch_i closes the batch. Output channel (out_valid_o /
// out_stall_i): one item per batch with the normalized loss (Q16.16), the
// count of positions taken and a bad label flag.
// Stalls: an item that does not close a position never stalls the input.
// An item that closes a counted position stalls the input while the log unit
// runs 20 squaring steps, the log2 assembly, the scale and the round. An item
// that ends the batch stalls it further for the normalizer, the divider
// start, 41 steps of the one-bit-a-cycle divider and the output register load.
// The output register holds its item while out_stall_i is high; the block
// keeps taking items of the next batch meanwhile and is held up by it only
// when a new result finds the output register still full.
// Reset clears all accumulation state and loads the register defaults
// (normalizer by valid count, ignore off, ignore label -1, counts of one).
// Configuration writes are taken at any edge with cfg_we_i high.
// ----------------------------------------------------------------------------
module softmax_cross_entropy_loss (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sce_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sce_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sce_pkg::PROB_W-1:0]      prob_i,
  input  logic signed [sce_pkg::LABEL_W-1:0] label_i,
  input  logic                            last_class_i,
  input  logic                            last_of_batch_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sce_pkg::LOSS_W-1:0]      loss_o,
  output logic [sce_pkg::CNT_W-1:0]       pos_count_o,
  output logic                            bad_label_o
);
  import sce_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOG, S_NORM, S_DSTART, S_DIV, S_OUT} state_e;

  // configuration registers
  logic [1:0]          norm_mode_q;
  logic                ignore_en_q;
  logic [LABEL_W-1:0]  ignore_label_q;
  logic [CFG_DATA_W-1:0] batch_count_q;
  logic [CFG_DATA_W-1:0] spatial_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_mode_q     <= NORM_VALID;
      ignore_en_q     <= 1'b0;
      ignore_label_q  <= {LABEL_W{1'b1}};
      batch_count_q   <= CFG_DATA_W'(1);
      spatial_count_q <= CFG_DATA_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NORM_MODE:     norm_mode_q     <= cfg_wdata_i[1:0];
        CFG_IGNORE_ENABLE: ignore_en_q     <= cfg_wdata_i[0];
        CFG_IGNORE_LABEL:  ignore_label_q  <= cfg_wdata_i[LABEL_W-1:0];
        CFG_BATCH_COUNT:   batch_count_q   <= cfg_wdata_i;
        CFG_SPATIAL_COUNT: spatial_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  state_e              state_q, state_d;
  logic [CI_W-1:0]     ci_q, ci_d;
  logic [PROB_W-1:0]   picked_q, picked_d;
  logic                matched_q, matched_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    counted_q, counted_d;
  logic                lerr_q, lerr_d;
  logic                batch_end_q, batch_end_d;
  logic [NORM_W-1:0]   norm_q, norm_d;
  logic                out_valid_q, out_valid_d;
  logic [LOSS_W-1:0]   loss_q, loss_d;
  logic [CNT_W-1:0]    vcnt_q, vcnt_d;
  logic                bad_q, bad_d;

  logic                accept;
  logic                close;
  logic                skip;
  logic                hit;
  logic [PROB_W-1:0]   p_sat;
  logic [PROB_W-1:0]   picked_eff;
  logic                matched_eff;
  logic                log_start;
  logic [PROB_W-1:0]   log_arg;
  logic                log_done;
  logic [TERM_W-1:0]   log_res;
  logic [SUM_W:0]      sum_add;
  logic                div_start;
  logic [DVD_W-1:0]    dividend;
  logic                div_done;
  logic [LOSS_W-1:0]   div_quo;
  logic [NORM_W-1:0]   norm_sel;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign close      = last_class_i || last_of_batch_i;
  assign skip       = ignore_en_q && (label_i == ignore_label_q);
  assign p_sat      = (prob_i > ONE_Q16) ? ONE_Q16 : prob_i;

  // class index still in range and equal to a non-negative label
  assign hit = !ci_q[CI_W-1] && !label_i[LABEL_W-1] &&
               (ci_q[CI_W-2:0] == label_i[LABEL_W-2:0]);

  assign picked_eff  = hit ? p_sat : picked_q;
  assign matched_eff = hit || matched_q;

  assign log_start = accept && close && !skip;
  assign log_arg   = (!matched_eff || picked_eff == '0) ? PROB_W'(1) : picked_eff;

  assign sum_add   = (SUM_W+1)'(sum_q) + (SUM_W+1)'(log_res);

  assign div_start = (state_q == S_DSTART);
  assign dividend  = (DVD_W)'(sum_q) + (DVD_W)'(norm_q >> 1);

  always_comb begin
    case (norm_mode_q)
      NORM_FULL:  norm_sel = NORM_W'(batch_count_q) * NORM_W'(spatial_count_q);
      NORM_VALID: norm_sel = NORM_W'(counted_q);
      NORM_BATCH: norm_sel = NORM_W'(batch_count_q);
      default:    norm_sel = NORM_W'(1);
    endcase
  end

  sce_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .q_i     (log_arg),
    .done_o  (log_done),
    .nlog_o  (log_res)
  );

  sce_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (norm_q),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    ci_d        = ci_q;
    picked_d    = picked_q;
    matched_d   = matched_q;
    sum_d       = sum_q;
    counted_d   = counted_q;
    lerr_d      = lerr_q;
    batch_end_d = batch_end_q;
    norm_d      = norm_q;
    out_valid_d = out_valid_q && out_stall_i;
    loss_d      = loss_q;
    vcnt_d      = vcnt_q;
    bad_d       = bad_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!close) begin
            picked_d  = picked_eff;
            matched_d = matched_eff;
            if (!ci_q[CI_W-1]) ci_d = ci_q + CI_W'(1);
          end else begin
            ci_d        = '0;
            picked_d    = '0;
            matched_d   = 1'b0;
            batch_end_d = last_of_batch_i;
            if (!skip) begin
              if (!matched_eff) lerr_d = 1'b1;
              if (counted_q != COUNT_MAX) counted_d = counted_q + CNT_W'(1);
              state_d = S_LOG;
            end else if (last_of_batch_i) begin
              state_d = S_NORM;
            end
          end
        end
      end
      S_LOG: begin
        if (log_done) begin
          sum_d   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
          state_d = batch_end_q ? S_NORM : S_IDLE;
        end
      end
      S_NORM: begin
        norm_d  = (norm_sel == '0) ? NORM_W'(1) : norm_sel;
        state_d = S_DSTART;
      end
      S_DSTART: state_d = S_DIV;
      S_DIV: begin
        if (div_done) state_d = S_OUT;
      end
      S_OUT: begin
        // load when the output register is free or being drained
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          loss_d      = div_quo;
          vcnt_d      = counted_q;
          bad_d       = lerr_q;
          sum_d       = '0;
          counted_d   = '0;
          lerr_d      = 1'b0;
          batch_end_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ci_q        <= '0;
      picked_q    <= '0;
      matched_q   <= 1'b0;
      sum_q       <= '0;
      counted_q   <= '0;
      lerr_q      <= 1'b0;
      batch_end_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ci_q        <= ci_d;
      picked_q    <= picked_d;
      matched_q   <= matched_d;
      sum_q       <= sum_d;
      counted_q   <= counted_d;
      lerr_q      <= lerr_d;
      batch_end_q <= batch_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    norm_q <= norm_d;
    loss_q <= loss_d;
    vcnt_q <= vcnt_d;
    bad_q  <= bad_d;
  end

  assign out_valid_o = out_valid_q;
  assign loss_o      = loss_q;
  assign pos_count_o = vcnt_q;
  assign bad_label_o = bad_q;

`include "softmax_cross_entropy_loss_assert.svh"

  `SCE_ASSERT_IMP(a_log_done_in_log, log_done, state_q == S_LOG)
  `SCE_ASSERT_IMP(a_div_done_in_div, div_done, state_q == S_DIV)
  `SCE_ASSERT_IMP(a_out_from_load, $rose(out_valid_q), $past(state_q) == S_OUT)
  `SCE_ASSERT_IMP(a_ci_bounded, 1'b1, ci_q <= CI_W'(MAX_CLASSES))
  `SCE_ASSERT_NXT(a_close_stalls, log_start, in_stall_o)

endmodule

// ----- tb/softmax_cross_entropy_loss_checker.sv -----
// ----------------------------------------------------------------------------
// softmax_cross_entropy_loss_checker
// Watches the configuration port and both item channels of the loss block.
// It keeps its own copy of the registers and the per-position state, works out
// the batch result for every item that closes a batch, and compares each
// result item taken from the block against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module softmax_cross_entropy_loss_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sce_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sce_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [sce_pkg::PROB_W-1:0]         prob_i,
  input  logic signed [sce_pkg::LABEL_W-1:0] label_i,
  input  logic                               last_class_i,
  input  logic                               last_of_batch_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [sce_pkg::LOSS_W-1:0]         loss_i,
  input  logic [sce_pkg::CNT_W-1:0]          pos_count_i,
  input  logic                               bad_label_i,
  output int                                 mismatch_count_o,
  output int                                 results_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import sce_pkg::*;

  typedef struct packed {
    logic [LOSS_W-1:0] loss;
    logic [CNT_W-1:0]  count;
    logic              bad;
  } batch_loss_t;

  batch_loss_t loss_due[$];

  // register copy
  logic [1:0]                 norm_sel;
  logic                       ign_on;
  logic signed [LABEL_W-1:0]  ign_lbl;
  logic [CFG_DATA_W-1:0]      n_batch;
  logic [CFG_DATA_W-1:0]      n_spatial;

  // running state of the current position and batch
  int                         cls_pos;
  logic [PROB_W-1:0]          held_prob;
  logic                       hit;
  longint unsigned            nll_sum;
  logic [CNT_W-1:0]           pos_count;
  logic                       label_fault;

  // -ln(q / 65536) in Q4.16, q from 1 to 65536
  function automatic logic [TERM_W-1:0] minus_ln(input logic [PROB_W-1:0] q);
    int              msb;
    int              b;
    longint unsigned m;
    longint unsigned frac;
    longint unsigned lg;
    msb  = 0;
    frac = 0;
    for (b = 0; b < PROB_W; b++)
      if (q[b]) msb = b;
    m = q;
    m = m << (16 - msb);
    // one bit of log2 per squaring of the mantissa
    for (b = 0; b < LOG_FRAC_BITS; b++) begin
      m    = (m * m) >> 16;
      frac = frac << 1;
      if (m >= 64'd131072) begin
        frac = frac | 64'd1;
        m    = m >> 1;
      end
    end
    lg = 16 - msb;
    lg = (lg << LOG_FRAC_BITS) - frac;
    return TERM_W'((lg * LN2_Q32 + (64'd1 << 35)) >> 36);
  endfunction

  function automatic void clear_batch();
    cls_pos     = 0;
    held_prob   = '0;
    hit         = 1'b0;
    nll_sum     = 0;
    pos_count   = '0;
    label_fault = 1'b0;
  endfunction

  function automatic void absorb(input logic [PROB_W-1:0] p_raw,
                                 input logic signed [LABEL_W-1:0] lab,
                                 input logic lc, input logic lob);
    logic [PROB_W-1:0] p;
    logic [PROB_W-1:0] q;
    int                lab_v;
    longint unsigned   norm;
    longint unsigned   quo;
    batch_loss_t       res;
    p     = (p_raw > ONE_Q16) ? ONE_Q16 : p_raw;
    lab_v = lab;
    if (cls_pos < MAX_CLASSES && lab_v >= 0 && lab_v == cls_pos) begin
      held_prob = p;
      hit       = 1'b1;
    end
    if (cls_pos < MAX_CLASSES) cls_pos++;

    // a batch end closes the open position too
    if (lc || lob) begin
      if (!(ign_on && lab == ign_lbl)) begin
        q = hit ? held_prob : '0;
        if (!hit) label_fault = 1'b1;
        if (q == '0) q = PROB_W'(1);
        nll_sum = nll_sum + minus_ln(q);
        if (nll_sum > SUM_MAX) nll_sum = SUM_MAX;
        if (pos_count != COUNT_MAX) pos_count++;
      end
      cls_pos   = 0;
      held_prob = '0;
      hit       = 1'b0;
    end

    if (lob) begin
      case (norm_sel)
        NORM_FULL: begin
          norm = n_batch;
          norm = norm * n_spatial;
        end
        NORM_VALID: norm = pos_count;
        NORM_BATCH: norm = n_batch;
        default:    norm = 1;
      endcase
      if (norm == 0) norm = 1;
      quo = (nll_sum + norm / 2) / norm;
      if (quo > 64'hFFFF_FFFF) quo = 64'hFFFF_FFFF;
      res.loss  = quo[LOSS_W-1:0];
      res.count = pos_count;
      res.bad   = label_fault;
      loss_due  = {loss_due, res};
      clear_batch();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    batch_loss_t want;
    if (!rst_ni) begin
      norm_sel  = NORM_VALID;
      ign_on    = 1'b0;
      ign_lbl   = -11'sd1;
      n_batch   = CFG_DATA_W'(1);
      n_spatial = CFG_DATA_W'(1);
      clear_batch();
      loss_due.delete();
      mismatch_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NORM_MODE:     norm_sel  = cfg_wdata_i[1:0];
          CFG_IGNORE_ENABLE: ign_on    = cfg_wdata_i[0];
          CFG_IGNORE_LABEL:  ign_lbl   = cfg_wdata_i;
          CFG_BATCH_COUNT:   n_batch   = cfg_wdata_i;
          CFG_SPATIAL_COUNT: n_spatial = cfg_wdata_i;
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i)
        absorb(prob_i, label_i, last_class_i, last_of_batch_i);

      if (out_valid_i && !out_stall_i) begin
        if (loss_due.size() == 0) begin
          $error("result item with none outstanding: loss %0d, pos_count %0d, bad_label %0d",
                 loss_i, pos_count_i, bad_label_i);
          mismatch_count_o++;
        end else begin
          want = loss_due.pop_front();
          if (loss_i !== want.loss) begin
            $error("loss: expected %0d, got %0d", want.loss, loss_i);
            mismatch_count_o++;
          end
          if (pos_count_i !== want.count) begin
            $error("pos_count: expected %0d, got %0d", want.count, pos_count_i);
            mismatch_count_o++;
          end
          if (bad_label_i !== want.bad) begin
            $error("bad_label: expected %0d, got %0d", want.bad, bad_label_i);
            mismatch_count_o++;
          end
        end
      end
    end
    results_due_o = loss_due.size();
  end

endmodule

// ----- tb/softmax_cross_entropy_loss_tb.sv -----
// ----------------------------------------------------------------------------
// softmax_cross_entropy_loss_tb
// Drives the loss block with streams of class probabilities: a short directed
// batch set for the corner cases, then random batches under a sweep of
// register settings, with random idle cycles on the sender and random stall
// on the receiver. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module softmax_cross_entropy_loss_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sce_pkg::*;

  localparam int ITEM_GOAL     = 1900;
  localparam int MAX_WAIT      = 11;
  localparam int SETTLE_CYCLES = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_idx;
  logic [CFG_DATA_W-1:0]     cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  logic [PROB_W-1:0]         prob;
  logic signed [LABEL_W-1:0] label;
  logic                      last_class;
  logic                      last_of_batch;
  logic                      out_valid;
  logic                      out_stall;
  logic [LOSS_W-1:0]         loss;
  logic [CNT_W-1:0]          pos_count;
  logic                      bad_label;

  int                        mismatches;
  int                        results_due;
  int                        items_sent;
  bit                        send_calm;
  bit                        take_calm;
  logic signed [LABEL_W-1:0] ign_label_now;

  softmax_cross_entropy_loss uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .prob_i          (prob),
    .label_i         (label),
    .last_class_i    (last_class),
    .last_of_batch_i (last_of_batch),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .loss_o          (loss),
    .pos_count_o     (pos_count),
    .bad_label_o     (bad_label)
  );

  softmax_cross_entropy_loss_checker chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .prob_i           (prob),
    .label_i          (label),
    .last_class_i     (last_class),
    .last_of_batch_i  (last_of_batch),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .loss_i           (loss),
    .pos_count_i      (pos_count),
    .bad_label_i      (bad_label),
    .mismatch_count_o (mismatches),
    .results_due_o    (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("softmax_cross_entropy_loss verification failed");
    $finish;
  end

  function automatic int pick_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  function automatic logic [PROB_W-1:0] pick_prob();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)       return '0;
    else if (r < 10) return ONE_Q16;
    else if (r < 15) return PROB_W'($urandom_range(65537, 131071));
    else if (r < 20) return PROB_W'($urandom_range(1, 16));
    else             return PROB_W'($urandom_range(0, 65536));
  endfunction

  function automatic logic signed [LABEL_W-1:0] pick_label(input int n_cls);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)                         return LABEL_W'($urandom_range(0, n_cls - 1));
    else if (r < 65)                    return ign_label_now;
    else if (r < 75)                    return -11'sd1;
    else if (r < 88 && n_cls < 1024)    return LABEL_W'($urandom_range(n_cls, 1023));
    else                                return LABEL_W'($urandom);
  endfunction

  // offer one item and hold it until taken
  task automatic push_item(input logic [PROB_W-1:0] p, input logic signed [LABEL_W-1:0] lab,
                           input logic lc, input logic lob);
    int gap;
    gap = pick_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    prob          <= p;
    label         <= lab;
    last_class    <= lc;
    last_of_batch <= lob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // drop valid, wait for all outstanding results, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic configure(input int phase);
    logic [1:0]                mode;
    logic                      ign;
    logic signed [LABEL_W-1:0] il;
    logic [CFG_DATA_W-1:0]     bc;
    logic [CFG_DATA_W-1:0]     sc;
    mode = (phase < 8) ? 2'(phase % 4) : 2'($urandom_range(0, 3));
    ign  = (phase % 3 != 1);
    case (phase % 6)
      0: begin bc = 11'd1;    sc = 11'd1;    il = -11'sd1;    end
      1: begin bc = 11'd1024; sc = 11'd1024; il = 11'sd0;     end
      2: begin bc = 11'd0;    sc = 11'd2047; il = 11'sd1023;  end
      3: begin bc = 11'd2047; sc = 11'd0;    il = -11'sd1024; end
      default: begin
        bc = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(1, 16));
        sc = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(1, 16));
        il = ($urandom_range(0, 3) == 0) ? -11'sd1 : LABEL_W'($urandom_range(0, 7));
      end
    endcase
    write_reg(CFG_NORM_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_IGNORE_ENABLE, CFG_DATA_W'(ign));
    write_reg(CFG_IGNORE_LABEL, il);
    write_reg(CFG_BATCH_COUNT, bc);
    write_reg(CFG_SPATIAL_COUNT, sc);
    // an index past the register list must leave everything alone
    if (phase % 5 == 4) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    ign_label_now = il;
  endtask

  // one position; with cut set the batch ends before the last class is flagged
  task automatic send_position(input int n_cls, input logic signed [LABEL_W-1:0] lab,
                               input bit vary, input bit ends_batch, input bit cut);
    int                        k;
    logic signed [LABEL_W-1:0] lab_k;
    bit                        closing;
    for (k = 0; k < n_cls; k++) begin
      lab_k   = (vary && $urandom_range(0, 9) == 0) ? pick_label(n_cls) : lab;
      closing = (k == n_cls - 1);
      push_item(pick_prob(), lab_k, closing && !cut, closing && ends_batch);
    end
  endtask

  task automatic random_batch(input bit with_long);
    int n_pos;
    int k;
    int n_cls;
    bit ends;
    n_pos     = $urandom_range(1, 6);
    send_calm = ($urandom_range(0, 3) == 0);
    for (k = 0; k < n_pos; k++) begin
      ends = (k == n_pos - 1);
      if (with_long && k == 0) begin
        // run up to or past the class limit with the label on one of the last two reachable classes
        send_position($urandom_range(MAX_CLASSES, MAX_CLASSES + 3),
                      LABEL_W'(1023 - $urandom_range(0, 1)), 1'b0, ends, 1'b0);
      end else begin
        n_cls = $urandom_range(1, 8);
        send_position(n_cls, pick_label(n_cls), 1'b1, ends,
                      ends && $urandom_range(0, 7) == 0);
      end
    end
  endtask

  initial begin : receiver
    int hold;
    out_stall <= 1'b0;
    take_calm = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 7) == 0) take_calm = !take_calm;
      hold = pick_wait(take_calm);
      out_stall <= (hold > 0);
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (hold > 0) begin
        repeat (hold - 1) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int phase;
    int n_batches;
    int b;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    prob          <= '0;
    label         <= '0;
    last_class    <= 1'b0;
    last_of_batch <= 1'b0;
    items_sent    = 0;
    send_calm     = 1'b0;
    ign_label_now = -11'sd1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners under the reset register values
    push_item('0, 11'sd0, 1'b0, 1'b0);          // zero probability on the label
    push_item(ONE_Q16, 11'sd0, 1'b1, 1'b0);
    push_item(17'd131071, 11'sd1, 1'b0, 1'b0);  // above one, saturates
    push_item(17'd131071, 11'sd1, 1'b1, 1'b0);
    push_item(17'd12345, -11'sd1, 1'b0, 1'b0);  // negative label
    push_item(17'd54321, -11'sd1, 1'b1, 1'b0);
    push_item(17'd100, 11'sd5, 1'b0, 1'b0);     // label past the last class
    push_item(17'd200, 11'sd5, 1'b1, 1'b0);
    push_item(17'd1000, 11'sd0, 1'b0, 1'b0);    // label changes within a position
    push_item(17'd30000, 11'sd1, 1'b1, 1'b0);
    push_item(17'd1, 11'sd0, 1'b1, 1'b0);       // smallest nonzero probability
    push_item(17'd40000, 11'sd0, 1'b0, 1'b1);   // batch ends inside a position
    push_item(ONE_Q16, 11'sd0, 1'b1, 1'b1);     // one-item batch
    push_item(17'd65535, -11'sd1024, 1'b1, 1'b1);
    settle();

    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      configure(phase);
      n_batches = $urandom_range(1, 4);
      for (b = 0; b < n_batches; b++)
        random_batch(phase == 3 && b == 0);
      settle();
      phase++;
    end

    @(negedge clk);
    if (mismatches == 0 && results_due == 0)
      $display("softmax_cross_entropy_loss verification clean");
    else
      $display("softmax_cross_entropy_loss verification failed");
    $finish;
  end

endmodule
